// File: hdl/wcs_pkg.sv
// Shared types, constants and helpers for the windowed channel statistics core.
// No dependencies; imported by every module of the block.
package wcs_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int CHAN_W           = 3;
    localparam int SAMPLE_W         = 32;
    localparam int TIME_W           = 48;
    localparam int STD_W            = 31;
    localparam int SQ_W             = 64;
    localparam int DIV_W            = 64;
    localparam int RAD_W            = 62;
    localparam int ROOT_W           = RAD_W / 2;

    localparam logic [SAMPLE_W-1:0] FLOOR_LOW   = 32'hFFA6_0000;
    localparam logic [SAMPLE_W-1:0] FLOOR_MINUS = 32'hFFFF_0000;
    localparam logic [SAMPLE_W-1:0] FLOOR_ZERO  = 32'h0000_0000;
    localparam logic [STD_W-1:0]    STD_MAX     = '1;
    localparam logic [31:0]         INTERVAL_RST = 32'd2000;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ACC, S_TIME, S_LOAD, S_DIV1, S_MUL,
        S_MSQ, S_DIV2, S_VAR, S_SQRT, S_EMIT, S_WAIT
    } state_t;

    // Restart value of a channel's running maximum
    function automatic logic [SAMPLE_W-1:0] floor_of(input int ch);
        logic [SAMPLE_W-1:0] f;
        if (ch < 3) f = FLOOR_LOW;
        else if (ch == 3) f = FLOOR_MINUS;
        else f = FLOOR_ZERO;
        return f;
    endfunction

endpackage

// File: hdl/windowed_channel_statistics_core.sv
// Windowed per-channel mean, standard deviation and maximum on Q16.16 samples.
// Depends on wcs_pkg, wcs_div and wcs_sqrt.
//
// Input stream s_axis: tuser carries the channel; signal channels take a
// sample from tdata[31:0], the timestamp channel (NUM_CHANNELS) a time in ms
// from tdata[79:32]. Other channel codes are dropped. Write cfg_data with
// cfg_valid to set the window length in ms (cfg_ready is always high).
// A signal word passes through accept, square and accumulate steps, the
// square coming from the registered multiplier. A closing timestamp emits
// one word per channel on m_axis, in channel order, tlast on the final one;
// each non-empty channel uses two 64-step passes of the shared divider and
// a 31-step pass of the square root unit, which is skipped when the variance
// saturates; an empty channel skips both units.
// s_axis_tready is low from acceptance until the item is fully handled.
// When m_axis_tready is low the result word holds and the sequencer waits.
// Reset clears all accumulators, sets maxima to their floors, the window
// start to zero and the interval to 2000 ms; no clearing pass is needed.
module windowed_channel_statistics_core #(
    parameter int NUM_CHANNELS = wcs_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_BITS   = wcs_pkg::COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,      // interval_ms
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // sample[31:0], time_ms[79:32]
    input  logic [2:0]   s_axis_tuser,  // channel[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,  // mean[31:0], std_dev[62:32], peak[94:63],
                                        // window_time[142:95], zero pad[143]
    output logic [3:0]   m_axis_tuser,  // stat_channel[2:0], empty_res[3]
    output logic         m_axis_tlast
);
    import wcs_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SUM_W = SAMPLE_W + COUNT_BITS;

    state_t state_reg, state_next;

    logic [31:0]           interval_reg;
    logic [TIME_W-1:0]     wstart_reg;
    logic [SUM_W-1:0]      sum_reg   [NUM_CHANNELS];
    logic [SQ_W-1:0]       sumsq_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] count_reg [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]   max_reg   [NUM_CHANNELS];

    logic [IDX_W-1:0]      ch_reg, k_reg, idx;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [63:0]           prod_reg;
    logic [31:0]           mul_a;
    logic [31:0]           am_reg;
    logic                  neg_reg;
    logic [47:0]           msq_reg;
    logic [63:0]           var_reg;
    logic [STD_W-1:0]      std_reg;

    logic [SUM_W-1:0]      cur_sum;
    logic [SQ_W-1:0]       cur_sumsq;
    logic [COUNT_BITS-1:0] cur_count;
    logic [SAMPLE_W-1:0]   cur_max;
    logic                  cur_empty, cur_full, close_win, var_sat;
    logic [48:0]           tdiff;
    logic [SUM_W-1:0]      sum_abs;
    logic [SQ_W:0]         sumsq_add;
    logic [46:0]           sq_val;
    logic [63:0]           q_round;
    logic [63:0]           sqa;

    logic                  div_start, div_done;
    logic [DIV_W-1:0]      div_dividend, div_q;
    logic [COUNT_BITS-1:0] div_r;
    logic                  sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;

    logic                  out_take;

    // Shared iterative units
    wcs_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cur_count),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    wcs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({var_reg[45:0], 16'h0000}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Read the selected channel's accumulators
    always_comb begin
        idx       = (state_reg == S_SQ || state_reg == S_ACC) ? ch_reg : k_reg;
        cur_sum   = sum_reg[idx];
        cur_sumsq = sumsq_reg[idx];
        cur_count = count_reg[idx];
        cur_max   = max_reg[idx];
        cur_empty = cur_count == '0;
        cur_full  = cur_count == '1;
        sum_abs   = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;
        tdiff     = {1'b0, time_reg} - {1'b0, wstart_reg};
        close_win = !tdiff[48] && (tdiff > {17'd0, interval_reg});
        sq_val    = 47'((prod_reg + 64'd32768) >> 16);
        sumsq_add = {1'b0, cur_sumsq} + {{(SQ_W - 47 + 1){1'b0}}, sq_val};
        q_round   = div_q + 64'({div_r, 1'b0} >= {1'b0, cur_count});
        sqa       = q_round;
        var_sat   = var_reg[63:46] != '0;
        mul_a     = (state_reg == S_SQ)
                  ? (sample_reg[31] ? 32'(-sample_reg) : sample_reg) : am_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid) begin
                if (s_axis_tuser < CHAN_W'(NUM_CHANNELS)) state_next = S_SQ;
                else if (s_axis_tuser == CHAN_W'(NUM_CHANNELS)) state_next = S_TIME;
            end
            S_SQ:   state_next = S_ACC;
            S_ACC:  state_next = S_IDLE;
            S_TIME: state_next = close_win ? S_LOAD : S_IDLE;
            S_LOAD: state_next = cur_empty ? S_EMIT : S_DIV1;
            S_DIV1: if (div_done) state_next = S_MUL;
            S_MUL:  state_next = S_MSQ;
            S_MSQ:  state_next = S_DIV2;
            S_DIV2: if (div_done) state_next = S_VAR;
            S_VAR:  state_next = var_sat ? S_EMIT : S_SQRT;
            S_SQRT: if (sqrt_done) state_next = S_EMIT;
            S_EMIT: state_next = S_WAIT;
            S_WAIT: if (out_take) begin
                state_next = (k_reg == IDX_W'(NUM_CHANNELS - 1)) ? S_IDLE : S_LOAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Unit controls and handshakes
    always_comb begin
        s_axis_tready = state_reg == S_IDLE;
        cfg_ready     = 1'b1;
        div_start     = (state_reg == S_LOAD && !cur_empty) || state_reg == S_MSQ;
        div_dividend  = (state_reg == S_LOAD) ? DIV_W'(sum_abs) : cur_sumsq;
        sqrt_start    = state_reg == S_VAR && !var_sat;
        out_take      = m_axis_tvalid && m_axis_tready;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            interval_reg <= INTERVAL_RST;
            wstart_reg   <= '0;
            k_reg        <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) interval_reg <= cfg_data;
            if (state_reg == S_TIME) begin
                k_reg <= '0;
                if (close_win) wstart_reg <= time_reg;
            end
            if (state_reg == S_EMIT) m_axis_tvalid <= 1'b1;
            else if (out_take) begin
                m_axis_tvalid <= 1'b0;
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Accumulators: update on a sample, restart on a delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                sum_reg[i]   <= '0;
                sumsq_reg[i] <= '0;
                count_reg[i] <= '0;
                max_reg[i]   <= floor_of(i);
            end
        end else if (state_reg == S_ACC && !cur_full) begin
            sum_reg[ch_reg]   <= cur_sum + SUM_W'($signed(sample_reg));
            sumsq_reg[ch_reg] <= sumsq_add[SQ_W] ? '1 : sumsq_add[SQ_W-1:0];
            count_reg[ch_reg] <= cur_count + 1'b1;
            if ($signed(sample_reg) > $signed(cur_max)) max_reg[ch_reg] <= sample_reg;
        end else if (state_reg == S_WAIT && out_take) begin
            sum_reg[k_reg]   <= '0;
            sumsq_reg[k_reg] <= '0;
            count_reg[k_reg] <= '0;
            max_reg[k_reg]   <= floor_of(int'(k_reg));
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_a);
        if (state_reg == S_IDLE && s_axis_tvalid) begin
            ch_reg     <= IDX_W'(s_axis_tuser);
            sample_reg <= s_axis_tdata[31:0];
            time_reg   <= s_axis_tdata[79:32];
        end
        if (state_reg == S_LOAD) neg_reg <= cur_sum[SUM_W-1];
        if (state_reg == S_DIV1 && div_done) am_reg <= q_round[31:0];
        if (state_reg == S_MSQ) msq_reg <= 48'((prod_reg + 64'd32768) >> 16);
        if (state_reg == S_DIV2 && div_done) begin
            var_reg <= ({16'd0, msq_reg} > sqa) ? {16'd0, msq_reg} - sqa
                                                 : sqa - {16'd0, msq_reg};
        end
        if (state_reg == S_VAR && var_sat) std_reg <= STD_MAX;
        if (state_reg == S_SQRT && sqrt_done) std_reg <= sqrt_root;
        if (state_reg == S_EMIT) begin
            m_axis_tdata[31:0]    <= cur_empty ? '0 : (neg_reg ? -am_reg : am_reg);
            m_axis_tdata[62:32]   <= cur_empty ? '0 : std_reg;
            m_axis_tdata[94:63]   <= cur_empty ? '0 : cur_max;
            m_axis_tdata[142:95]  <= time_reg;
            m_axis_tdata[143]     <= 1'b0;
            m_axis_tuser[2:0]     <= CHAN_W'(k_reg);
            m_axis_tuser[3]       <= cur_empty;
            m_axis_tlast          <= k_reg == IDX_W'(NUM_CHANNELS - 1);
        end
    end

endmodule

// File: hdl/wcs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wcs_pkg.
module wcs_div #(
    parameter int COUNT_BITS = wcs_pkg::COUNT_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wcs_pkg::DIV_W-1:0] dividend,
    input  logic [COUNT_BITS-1:0]     divisor,
    output logic                      done,
    output logic [wcs_pkg::DIV_W-1:0] quotient,
    output logic [COUNT_BITS-1:0]     remainder
);
    import wcs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]      work_reg;
    logic [COUNT_BITS-1:0] rem_reg, dvs_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg, done_reg;
    logic [COUNT_BITS:0]   shifted, diff;
    logic                  ge;

    // One shift-subtract step
    always_comb begin
        shifted  = {rem_reg, work_reg[DIV_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end

    // Sequence the steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and shift quotient bits in
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            work_reg <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            work_reg <= {work_reg[DIV_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/wcs_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on wcs_pkg.
module wcs_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [wcs_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [wcs_pkg::ROOT_W-1:0] root
);
    import wcs_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg, shifted, trial;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg, ge;

    // Trial subtract for the next root bit
    always_comb begin
        shifted = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = shifted >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? shifted - trial : shifted;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for windowed_channel_statistics_core: random and directed streams,
// a per-channel window predictor and scoreboard, randomized stalls on both sides.
// Depends on wcs_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wcs_pkg::*;

    localparam int  NCH        = NUM_CHANNELS_DEF;
    localparam int  TS_CHANNEL = NCH;
    localparam int  BAD_CHANNEL = 7;
    localparam longint unsigned CNT_FULL = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  SETTLE      = 40;

    typedef struct {
        logic [CHAN_W-1:0]   chan;
        logic [31:0]         mean;
        logic [STD_W-1:0]    std_dev;
        logic [31:0]         peak;
        logic                empty;
        logic [TIME_W-1:0]   wtime;
        logic                last;
    } stat_word_t;

    // Window predictor and store of pending channel statistics
    class window_stats_board;
        longint          acc_sum [NCH];
        longint unsigned acc_sq  [NCH];
        longint unsigned n_samp  [NCH];
        int              run_max [NCH];
        longint unsigned win_start;
        longint unsigned interval;
        stat_word_t      pending_stats[$];
        int              fails;
        int              windows_closed;

        function new();
            for (int k = 0; k < NCH; k++) restart(k);
            win_start = 0;
            interval = INTERVAL_RST;
            fails = 0;
            windows_closed = 0;
        endfunction

        function void restart(int k);
            acc_sum[k] = 0;
            acc_sq[k]  = 0;
            n_samp[k]  = 0;
            run_max[k] = int'(floor_of(k));
        endfunction

        function longint unsigned quot_round(longint unsigned a, longint unsigned n);
            longint unsigned q, r;
            q = a / n;
            r = a % n;
            if (r >= n - r) q++;
            return q;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Update state for one accepted input word; queue results on a window close
        function void note_word(int ch, int s, longint unsigned t);
            longint unsigned mag, sq, am, msq, sqa, vr, sd;
            longint diff;
            bit neg;
            stat_word_t w;
            if (ch < NCH) begin
                if (n_samp[ch] >= CNT_FULL) return;
                mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
                sq = (mag * mag + 32768) >> 16;
                acc_sum[ch] += s;
                acc_sq[ch] = (acc_sq[ch] > ~sq) ? ~64'd0 : acc_sq[ch] + sq;
                n_samp[ch]++;
                if (s > run_max[ch]) run_max[ch] = s;
                return;
            end
            if (ch != TS_CHANNEL) return;
            diff = longint'(t) - longint'(win_start);
            if (diff <= longint'(interval)) return;
            win_start = t;
            windows_closed++;
            for (int k = 0; k < NCH; k++) begin
                w.chan = CHAN_W'(k);
                w.mean = '0;
                w.std_dev = '0;
                w.peak = '0;
                w.empty = (n_samp[k] == 0);
                w.wtime = t[TIME_W-1:0];
                w.last = (k == NCH - 1);
                if (n_samp[k] != 0) begin
                    neg = acc_sum[k] < 0;
                    am = quot_round(neg ? -acc_sum[k] : acc_sum[k], n_samp[k]);
                    msq = (am * am + 32768) >> 16;
                    sqa = quot_round(acc_sq[k], n_samp[k]);
                    vr = (msq > sqa) ? msq - sqa : sqa - msq;
                    sd = (vr >= (64'd1 << 46)) ? 64'h7FFF_FFFF : root_floor(vr << 16);
                    if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
                    w.mean = neg ? -am[31:0] : am[31:0];
                    w.std_dev = sd[STD_W-1:0];
                    w.peak = run_max[k];
                end
                pending_stats = {pending_stats, w};
                restart(k);
            end
        endfunction

        function void check_word(logic [143:0] d, logic [3:0] u, logic l);
            stat_word_t e;
            if (pending_stats.size() == 0) begin
                $error("unexpected result word: chan %0d", u[2:0]);
                fails++;
                return;
            end
            e = pending_stats.pop_front();
            if (u[2:0] !== e.chan) begin
                $error("stat_channel: expected %0d actual %0d", e.chan, u[2:0]);
                fails++;
            end
            if (d[31:0] !== e.mean) begin
                $error("mean: expected %h actual %h", e.mean, d[31:0]);
                fails++;
            end
            if (d[62:32] !== e.std_dev) begin
                $error("std_dev: expected %h actual %h", e.std_dev, d[62:32]);
                fails++;
            end
            if (d[94:63] !== e.peak) begin
                $error("peak: expected %h actual %h", e.peak, d[94:63]);
                fails++;
            end
            if (u[3] !== e.empty) begin
                $error("empty_res: expected %0d actual %0d", e.empty, u[3]);
                fails++;
            end
            if (d[142:95] !== e.wtime) begin
                $error("window_time: expected %0d actual %0d", e.wtime, d[142:95]);
                fails++;
            end
            if (l !== e.last) begin
                $error("last: expected %0d actual %0d", e.last, l);
                fails++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // sample[31:0], time_ms[79:32]
    logic [2:0]   s_axis_tuser;   // channel[2:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // mean, std_dev, peak, window_time, pad
    logic [3:0]   m_axis_tuser;   // stat_channel[2:0], empty_res[3]
    logic         m_axis_tlast;

    window_stats_board board = new();
    bit              quiet;       // no idling on either side while set
    longint unsigned now_ms;
    int              stall_left;
    int              rx_gap;
    int              cycles = 0;

    windowed_channel_statistics_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Check result words and stall the receiver at random
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (!aresetn) begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            rx_gap = quiet ? 0 : $urandom_range(0, 16);
            if (rx_gap > 0) begin
                stall_left <= rx_gap;
                m_axis_tready <= 1'b0;
            end
        end else if (!m_axis_tready) begin
            if (stall_left <= 1) m_axis_tready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // Drive one input word after a random gap; hold it until accepted
    task automatic send_word(int ch, int s, longint unsigned t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ch[2:0];
        s_axis_tdata <= {t[TIME_W-1:0], s};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_word(ch, s, t & TIME_MAX);
    endtask

    task automatic stamp(longint unsigned t);
        now_ms = t;
        send_word(TS_CHANNEL, $urandom, t);
    endtask

    // Hold off until every pending result has drained and the core settles
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_interval(logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.interval = v;
    endtask

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return int'($urandom_range(0, 2_000_000)) - 1_000_000;
        if (r < 8) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // One random word: mostly samples, some timestamps, a few dropped codes
    task automatic random_word();
        int r;
        longint unsigned step;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            send_word($urandom_range(0, NCH - 1), pick_sample(), $urandom);
        end else if (r < 95) begin
            r = $urandom_range(0, 99);
            if (r < 60) step = now_ms + board.interval + $urandom_range(1, 300);
            else if (r < 85) step = now_ms + $urandom_range(0, board.interval);
            else step = now_ms - $urandom_range(0, 50);
            stamp(step);
        end else begin
            send_word(BAD_CHANNEL, $urandom, {$urandom, $urandom});
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        quiet = 1'b0;
        now_ms = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes per channel, channel 3 left empty, default interval
        send_word(0, 32'h7FFF_FFFF, 0);
        send_word(0, 32'h8000_0000, TIME_MAX);
        send_word(1, -1, 0);
        send_word(2, 32'h0005_8000, 0);
        send_word(4, 0, 0);
        send_word(5, -3, 0);
        stamp(0);
        stamp(2000);
        stamp(1000);
        send_word(BAD_CHANNEL, 32'h1234_5678, 2500);
        stamp(2001);
        stamp(1500);

        // Zero interval: any forward step closes
        write_interval(0);
        send_word(3, 32'h0001_0000, 0);
        stamp(2001);
        stamp(2002);

        // Widest interval
        write_interval(32'hFFFF_FFFF);
        send_word(1, 32'h0040_0000, 0);
        stamp(2002 + 64'hFFFF_FFFF);
        stamp(2003 + 64'hFFFF_FFFF);

        // Random phases under changing intervals
        for (int ph = 0; ph < 4; ph++) begin
            write_interval((ph == 3) ? 32'd1 : $urandom_range(1, 400));
            for (int i = 0; i < 60; i++) begin
                if (i % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
                random_word();
            end
        end
        quiet = 1'b0;

        // Final window closes at the top of the time range
        drain();
        send_word(2, pick_sample(), 0);
        stamp(TIME_MAX);
        drain();

        if (board.fails == 0 && board.pending_stats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
